/* sv/drp_pkg.sv */
`default_nettype none
package drp_pkg;

    // Default values for the top-level parameters.
    localparam int DISP_FRAC_BITS_DEF = 4;
    localparam int COORD_BITS_DEF     = 12;

    // Fixed field and register widths.
    localparam int DISP_W    = 16;
    localparam int MAG_W     = DISP_W - 1;
    localparam int BF_W      = 32;
    localparam int INVF_W    = 24;
    localparam int CTR_W     = 16;
    localparam int OFF_W     = 32;
    localparam int PT_W      = 32;
    localparam int Z_W       = 31;
    localparam int CTR_FRAC  = 4;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 5;
    localparam int REG_IDX_W = 3;

    localparam int QUEUE_DEPTH = 4;

    // Register indexes on the configuration port.
    localparam logic [REG_IDX_W-1:0] REG_BASELINE_FOCAL = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_INV_FOCAL_X    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_INV_FOCAL_Y    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_CENTER_X       = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_CENTER_Y       = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_OFFSET_X       = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_OFFSET_Y       = 3'd6;

endpackage
`default_nettype wire

/* sv/drp_front.sv */
`default_nettype none
module drp_front #(
    parameter int COORD_BITS = drp_pkg::COORD_BITS_DEF
) (
    input  wire logic                                      aclk,
    input  wire logic                                      aresetn,
    input  wire logic                                      in_valid,
    output logic                                           in_ready,
    input  wire logic signed [drp_pkg::DISP_W-1:0]         in_disparity,
    input  wire logic [COORD_BITS-1:0]                     in_col,
    input  wire logic [COORD_BITS-1:0]                     in_row,
    input  wire logic                                      q_full,
    output logic                                           q_push,
    output logic [drp_pkg::MAG_W+2*COORD_BITS-1:0]         q_data
);
    import drp_pkg::*;

    localparam int ENT_W = MAG_W + 2 * COORD_BITS;

    logic             fr_valid_reg;
    logic             fr_keep_reg;
    logic [ENT_W-1:0] fr_data_reg;
    logic             fr_free;
    logic             keep;

    // A pixel is kept only when its disparity is strictly positive.
    assign keep     = !in_disparity[DISP_W-1] && (|in_disparity[MAG_W-1:0]);
    assign fr_free  = !fr_valid_reg || !fr_keep_reg || !q_full;
    assign in_ready = fr_free;
    assign q_push   = fr_valid_reg && fr_keep_reg && !q_full;
    assign q_data   = fr_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fr_valid_reg <= 1'b0;
            fr_keep_reg  <= 1'b0;
        end else if (fr_free) begin
            fr_valid_reg <= in_valid;
            fr_keep_reg  <= keep;
        end
    end

    always_ff @(posedge aclk) begin
        if (fr_free && in_valid) begin
            fr_data_reg <= {in_row, in_col, in_disparity[MAG_W-1:0]};
        end
    end

endmodule
`default_nettype wire

/* sv/drp_queue.sv */
`default_nettype none
module drp_queue #(
    parameter int WIDTH = 39,
    parameter int DEPTH = drp_pkg::QUEUE_DEPTH
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data,
    output logic                  empty
);
    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW:0]      count_reg;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == (AW+1)'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

/* sv/drp_back.sv */
`default_nettype none
module drp_back #(
    parameter int DISP_FRAC_BITS = drp_pkg::DISP_FRAC_BITS_DEF,
    parameter int COORD_BITS     = drp_pkg::COORD_BITS_DEF
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic [drp_pkg::BF_W-1:0]              baseline_focal,
    input  wire logic [drp_pkg::INVF_W-1:0]            inv_focal_x,
    input  wire logic [drp_pkg::INVF_W-1:0]            inv_focal_y,
    input  wire logic [drp_pkg::CTR_W-1:0]             center_x,
    input  wire logic [drp_pkg::CTR_W-1:0]             center_y,
    input  wire logic signed [drp_pkg::OFF_W-1:0]      offset_x,
    input  wire logic signed [drp_pkg::OFF_W-1:0]      offset_y,
    input  wire logic                                  q_empty,
    input  wire logic [drp_pkg::MAG_W+2*COORD_BITS-1:0] q_data,
    output logic                                       q_pop,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic signed [drp_pkg::PT_W-1:0]            point_x,
    output logic signed [drp_pkg::PT_W-1:0]            point_y,
    output logic [drp_pkg::Z_W-1:0]                    point_z,
    output logic [COORD_BITS-1:0]                      out_col,
    output logic [COORD_BITS-1:0]                      out_row
);
    import drp_pkg::*;

    localparam int QW    = BF_W + DISP_FRAC_BITS;
    localparam int CW    = COORD_BITS;
    localparam int SC_W  = (CW + CTR_FRAC > CTR_W) ? CW + CTR_FRAC : CTR_W;
    localparam int DU_W  = SC_W + 1;
    localparam int MP_W  = DU_W + Z_W + 1;
    localparam int T_W   = MP_W - CTR_FRAC + 1;
    localparam int TH_W  = T_W - INVF_W;
    localparam int HI_W  = TH_W + INVF_W + 1;
    localparam int LO_W  = 2 * INVF_W;
    localparam int SUM_W = HI_W + 1;

    logic en;

    // ---------------- divider: one quotient bit per stage ----------------
    logic            dv_vld_reg [QW+1];
    logic [MAG_W-1:0] dv_rem_reg [QW+1];
    logic [QW-1:0]   dv_num_reg [QW+1];
    logic [QW-1:0]   dv_quo_reg [QW+1];
    logic [MAG_W-1:0] dv_div_reg [QW+1];
    logic [CW-1:0]   dv_col_reg [QW+1];
    logic [CW-1:0]   dv_row_reg [QW+1];

    assign en    = !out_valid || out_ready;
    assign q_pop = en && !q_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_vld_reg[0] <= 1'b0;
        end else if (en) begin
            dv_vld_reg[0] <= !q_empty;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dv_rem_reg[0] <= '0;
            dv_num_reg[0] <= {baseline_focal, {DISP_FRAC_BITS{1'b0}}};
            dv_quo_reg[0] <= '0;
            dv_div_reg[0] <= q_data[MAG_W-1:0];
            dv_col_reg[0] <= q_data[MAG_W +: CW];
            dv_row_reg[0] <= q_data[MAG_W+CW +: CW];
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_div
        logic [MAG_W:0] trial;
        logic           ge;
        logic [MAG_W:0] diff;

        assign trial = {dv_rem_reg[k], dv_num_reg[k][QW-1]};
        assign ge    = trial >= {1'b0, dv_div_reg[k]};
        assign diff  = trial - {1'b0, dv_div_reg[k]};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_vld_reg[k+1] <= 1'b0;
            end else if (en) begin
                dv_vld_reg[k+1] <= dv_vld_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dv_rem_reg[k+1] <= ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
                dv_num_reg[k+1] <= {dv_num_reg[k][QW-2:0], 1'b0};
                dv_quo_reg[k+1] <= {dv_quo_reg[k][QW-2:0], ge};
                dv_div_reg[k+1] <= dv_div_reg[k];
                dv_col_reg[k+1] <= dv_col_reg[k];
                dv_row_reg[k+1] <= dv_row_reg[k];
            end
        end
    end

    // ---------------- projection stages ----------------
    logic                    a_vld_reg, b_vld_reg, c_vld_reg, d_vld_reg, e_vld_reg;
    logic [Z_W-1:0]          a_z_reg, b_z_reg, c_z_reg, d_z_reg, e_z_reg;
    logic [CW-1:0]           a_col_reg, b_col_reg, c_col_reg, d_col_reg, e_col_reg;
    logic [CW-1:0]           a_row_reg, b_row_reg, c_row_reg, d_row_reg, e_row_reg;
    logic signed [DU_W-1:0]  a_dux_reg, a_duy_reg;
    logic signed [MP_W-1:0]  b_mx_reg, b_my_reg;
    logic signed [T_W-1:0]   c_tx_reg, c_ty_reg;
    logic signed [HI_W-1:0]  d_hx_reg, d_hy_reg;
    logic [INVF_W-1:0]       d_lx_reg, d_ly_reg;
    logic signed [PT_W-1:0]  e_x_reg, e_y_reg;

    logic [Z_W-1:0]          z_next;
    logic signed [DU_W-1:0]  dux_next, duy_next;
    logic [LO_W-1:0]         lx_full, ly_full;
    logic signed [SUM_W-1:0] sx, sy;

    function automatic logic signed [PT_W-1:0] sat_pt(input logic signed [SUM_W-1:0] v);
        logic fits;
        fits = (v[SUM_W-1:PT_W-1] == '0) || (v[SUM_W-1:PT_W-1] == '1);
        if (fits) begin
            return v[PT_W-1:0];
        end else if (v[SUM_W-1]) begin
            return {1'b1, {(PT_W-1){1'b0}}};
        end else begin
            return {1'b0, {(PT_W-1){1'b1}}};
        end
    endfunction

    // Depth saturates when any quotient bit lies above the 31-bit range.
    assign z_next = (|dv_quo_reg[QW][QW-1:Z_W]) ? {Z_W{1'b1}} : dv_quo_reg[QW][Z_W-1:0];
    assign dux_next = $signed({1'b0, SC_W'({dv_col_reg[QW], {CTR_FRAC{1'b0}}})})
                    - $signed({1'b0, SC_W'(center_x)});
    assign duy_next = $signed({1'b0, SC_W'({dv_row_reg[QW], {CTR_FRAC{1'b0}}})})
                    - $signed({1'b0, SC_W'(center_y)});

    // The correction term is floor(low 24 bits of t times f / 2^24).
    assign lx_full = c_tx_reg[INVF_W-1:0] * inv_focal_x;
    assign ly_full = c_ty_reg[INVF_W-1:0] * inv_focal_y;

    assign sx = SUM_W'(d_hx_reg) + SUM_W'($signed({1'b0, d_lx_reg}));
    assign sy = SUM_W'(d_hy_reg) + SUM_W'($signed({1'b0, d_ly_reg}));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
            e_vld_reg <= 1'b0;
        end else if (en) begin
            a_vld_reg <= dv_vld_reg[QW];
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
            d_vld_reg <= c_vld_reg;
            e_vld_reg <= d_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_z_reg   <= z_next;
            a_col_reg <= dv_col_reg[QW];
            a_row_reg <= dv_row_reg[QW];
            a_dux_reg <= dux_next;
            a_duy_reg <= duy_next;

            b_z_reg   <= a_z_reg;
            b_col_reg <= a_col_reg;
            b_row_reg <= a_row_reg;
            b_mx_reg  <= MP_W'(a_dux_reg * $signed({1'b0, a_z_reg}));
            b_my_reg  <= MP_W'(a_duy_reg * $signed({1'b0, a_z_reg}));

            c_z_reg   <= b_z_reg;
            c_col_reg <= b_col_reg;
            c_row_reg <= b_row_reg;
            c_tx_reg  <= T_W'(b_mx_reg >>> CTR_FRAC) - T_W'(offset_x);
            c_ty_reg  <= T_W'(b_my_reg >>> CTR_FRAC) - T_W'(offset_y);

            d_z_reg   <= c_z_reg;
            d_col_reg <= c_col_reg;
            d_row_reg <= c_row_reg;
            d_hx_reg  <= HI_W'($signed(c_tx_reg[T_W-1:INVF_W]) * $signed({1'b0, inv_focal_x}));
            d_hy_reg  <= HI_W'($signed(c_ty_reg[T_W-1:INVF_W]) * $signed({1'b0, inv_focal_y}));
            d_lx_reg  <= lx_full[LO_W-1:INVF_W];
            d_ly_reg  <= ly_full[LO_W-1:INVF_W];

            e_z_reg   <= d_z_reg;
            e_col_reg <= d_col_reg;
            e_row_reg <= d_row_reg;
            e_x_reg   <= sat_pt(sx);
            e_y_reg   <= sat_pt(sy);
        end
    end

    assign out_valid = e_vld_reg;
    assign point_x   = e_x_reg;
    assign point_y   = e_y_reg;
    assign point_z   = e_z_reg;
    assign out_col   = e_col_reg;
    assign out_row   = e_row_reg;

endmodule
`default_nettype wire

/* sv/disparity_to_point_reprojection.sv */
`default_nettype none
// Stereo disparity to 3-D point reprojection. Each input item is one disparity pixel
// (signed Q12.4 disparity, column, row); pixels whose disparity is zero or negative are
// dropped and give no output item. For the others the block computes the depth
// Z = (baseline_focal << DISP_FRAC_BITS) / disparity, saturated to 31 bits, and then
// X = inv_focal_x * ((col - center_x) * Z - offset_x) and the matching Y, all rounded
// toward minus infinity and saturated to signed Q16.16. The block takes one item per
// clock while the output is not stalled; an item passes through the front register,
// the four-entry queue between front and back end, and then the back end (one
// restoring-divider stage per quotient bit, then five multiply and saturate stages).
// Backpressure on the output stalls the back end as a whole; the front keeps accepting
// items until the queue is full. Configuration registers are written over the APB port
// at byte address 4*index and must only be changed while no item is in flight.
module disparity_to_point_reprojection #(
    parameter int DISP_FRAC_BITS = drp_pkg::DISP_FRAC_BITS_DEF,
    parameter int COORD_BITS     = drp_pkg::COORD_BITS_DEF
) (
    input  wire logic                                         aclk,
    input  wire logic                                         aresetn,
    input  wire logic                                         s_tvalid,
    output logic                                              s_tready,
    // disparity, col, row from the lowest bit up
    input  wire logic [((drp_pkg::DISP_W+2*COORD_BITS+7)/8)*8-1:0] s_tdata,
    output logic                                              m_tvalid,
    input  wire logic                                         m_tready,
    // point_x, point_y, point_z, out_col, out_row from the lowest bit up
    output logic [((2*drp_pkg::PT_W+drp_pkg::Z_W+2*COORD_BITS+7)/8)*8-1:0] m_tdata,
    input  wire logic                                         psel,
    input  wire logic                                         penable,
    input  wire logic                                         pwrite,
    input  wire logic [drp_pkg::APB_AW-1:0]                   paddr,
    input  wire logic [drp_pkg::APB_DW-1:0]                   pwdata,
    output logic [drp_pkg::APB_DW-1:0]                        prdata,
    output logic                                              pready
);
    import drp_pkg::*;

    localparam int ENT_W      = MAG_W + 2 * COORD_BITS;
    localparam int M_FIELDS_W = 2 * PT_W + Z_W + 2 * COORD_BITS;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // Configuration registers.
    logic [BF_W-1:0]          baseline_focal_reg;
    logic [INVF_W-1:0]        inv_focal_x_reg;
    logic [INVF_W-1:0]        inv_focal_y_reg;
    logic [CTR_W-1:0]         center_x_reg;
    logic [CTR_W-1:0]         center_y_reg;
    logic signed [OFF_W-1:0]  offset_x_reg;
    logic signed [OFF_W-1:0]  offset_y_reg;
    logic                     cfg_wr;
    logic [REG_IDX_W-1:0]     cfg_idx;

    logic                     q_push, q_pop, q_full, q_empty;
    logic [ENT_W-1:0]         q_in, q_out;

    logic signed [PT_W-1:0]   point_x, point_y;
    logic [Z_W-1:0]           point_z;
    logic [COORD_BITS-1:0]    out_col, out_row;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[APB_AW-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            baseline_focal_reg <= '0;
            inv_focal_x_reg    <= '0;
            inv_focal_y_reg    <= '0;
            center_x_reg       <= '0;
            center_y_reg       <= '0;
            offset_x_reg       <= '0;
            offset_y_reg       <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_BASELINE_FOCAL: baseline_focal_reg <= pwdata;
                REG_INV_FOCAL_X:    inv_focal_x_reg    <= pwdata[INVF_W-1:0];
                REG_INV_FOCAL_Y:    inv_focal_y_reg    <= pwdata[INVF_W-1:0];
                REG_CENTER_X:       center_x_reg       <= pwdata[CTR_W-1:0];
                REG_CENTER_Y:       center_y_reg       <= pwdata[CTR_W-1:0];
                REG_OFFSET_X:       offset_x_reg       <= pwdata;
                REG_OFFSET_Y:       offset_y_reg       <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_BASELINE_FOCAL: prdata = baseline_focal_reg;
            REG_INV_FOCAL_X:    prdata = APB_DW'(inv_focal_x_reg);
            REG_INV_FOCAL_Y:    prdata = APB_DW'(inv_focal_y_reg);
            REG_CENTER_X:       prdata = APB_DW'(center_x_reg);
            REG_CENTER_Y:       prdata = APB_DW'(center_y_reg);
            REG_OFFSET_X:       prdata = offset_x_reg;
            REG_OFFSET_Y:       prdata = offset_y_reg;
            default:            prdata = '0;
        endcase
    end

    // The front register drops pixels with no valid disparity.
    drp_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_disparity (s_tdata[DISP_W-1:0]),
        .in_col       (s_tdata[DISP_W +: COORD_BITS]),
        .in_row       (s_tdata[DISP_W+COORD_BITS +: COORD_BITS]),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_data       (q_in)
    );

    drp_queue #(
        .WIDTH(ENT_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    drp_back #(
        .DISP_FRAC_BITS(DISP_FRAC_BITS),
        .COORD_BITS    (COORD_BITS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .baseline_focal (baseline_focal_reg),
        .inv_focal_x    (inv_focal_x_reg),
        .inv_focal_y    (inv_focal_y_reg),
        .center_x       (center_x_reg),
        .center_y       (center_y_reg),
        .offset_x       (offset_x_reg),
        .offset_y       (offset_y_reg),
        .q_empty        (q_empty),
        .q_data         (q_out),
        .q_pop          (q_pop),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .point_x        (point_x),
        .point_y        (point_y),
        .point_z        (point_z),
        .out_col        (out_col),
        .out_row        (out_row)
    );

    assign m_tdata = M_TDATA_W'({out_row, out_col, point_z, point_y, point_x});

endmodule
`default_nettype wire

/* sv/drp_checker.sv */
`default_nettype none
module drp_checker #(
    parameter int M_W = 120
) (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         m_tvalid,
    input wire logic                         m_tready,
    input wire logic [M_W-1:0]               m_tdata,
    input wire logic                         psel,
    input wire logic                         penable,
    input wire logic                         pwrite,
    input wire logic [drp_pkg::APB_AW-1:0]   paddr,
    input wire logic [drp_pkg::APB_DW-1:0]   pwdata,
    input wire logic [drp_pkg::APB_DW-1:0]   prdata,
    input wire logic                         pready
);
    import drp_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output item changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_pready: assert property (@(posedge aclk) pready)
        else $error("pready low");

    a_bf_readback: assert property (@(posedge aclk) disable iff (!aresetn)
        psel && penable && pwrite && (paddr == APB_AW'(0)) ##1 (paddr == APB_AW'(0))
        |-> prdata == $past(pwdata))
        else $error("baseline register readback mismatch");

endmodule

bind disparity_to_point_reprojection drp_checker #(
    .M_W(M_TDATA_W)
) u_drp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
);
`default_nettype wire
